// ===== rtl/fvs_pkg.sv =====
// Shared types, constants and coefficient function for the formant vowel synthesizer.
// No dependencies; every other file of the block imports this package.
package fvs_pkg;

  // Parameter defaults.
  localparam int unsigned BAND_COUNT_DEF  = 3;
  localparam int unsigned SINE_DEPTH_DEF  = 256;
  localparam int unsigned EXP_DEPTH_DEF   = 256;
  localparam int unsigned COEF_WIDTH_DEF  = 24;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Linear congruential generator.
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;
  localparam logic [31:0] PITCH_SEED_RST = 32'd12345;
  localparam logic [31:0] NOISE_SEED_RST = 32'd99;

  // Configuration register reset values.
  localparam logic [31:0] BASE_INC_RST    = 32'd11581800;
  localparam logic [15:0] VIB_DEPTH_RST   = 16'd22938;
  localparam logic [31:0] VIB_INC_RST     = 32'd535653;
  localparam logic [15:0] DRIFT_STEP_RST  = 16'd26;
  localparam logic [14:0] DRIFT_LIMIT_RST = 15'd13107;
  localparam logic [15:0] NOISE_LEVEL_RST = 16'd3277;
  localparam logic [15:0] OUT_GAIN_RST    = 16'd4096;
  localparam logic [19:0] RUN_LENGTH_RST  = 20'd88200;

  // Band-pass coefficients in Q2.30; bands beyond the third are silent.
  localparam logic signed [63:0] B0_Q30 [8] = '{64'sd6157536, 64'sd9148033, 64'sd19945077,
    64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0};
  localparam logic signed [63:0] A1_Q30 [8] = '{-64'sd2123630602, -64'sd2103564064,
    -64'sd1981515374, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0};
  localparam logic signed [63:0] A2_Q30 [8] = '{64'sd1061426712, 64'sd1055445757,
    64'sd1033851672, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0};
  localparam logic signed [63:0] GAIN_Q30 [8] = '{64'sd1073741824, 64'sd751619277,
    64'sd375809638, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0};

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_BASE_INC    = 3'd0,
    CFG_VIB_DEPTH   = 3'd1,
    CFG_VIB_INC     = 3'd2,
    CFG_DRIFT_STEP  = 3'd3,
    CFG_DRIFT_LIMIT = 3'd4,
    CFG_NOISE_LEVEL = 3'd5,
    CFG_OUT_GAIN    = 3'd6,
    CFG_RUN_LENGTH  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    COEF_B0, COEF_A1, COEF_A2, COEF_GAIN
  } coef_kind_e;

  // Operand selection of the shared multiplier.
  typedef enum logic [4:0] {
    M_NONE, M_PLCG, M_NLCG, M_DRIFT, M_Z2, M_T1, M_T2, M_S, M_BEND, M_DIV,
    M_E1, M_E2, M_E3, M_STEP, M_FB0, M_FA1, M_FA2, M_FG, M_NOISE, M_OUT
  } mul_op_e;

  // Destination of the registered product.
  typedef enum logic [4:0] {
    W_NONE, W_PSEED, W_NSEED, W_DRIFT, W_Z2, W_SINE, W_BEND, W_DIV, W_ENTRY,
    W_STEP, W_ACC0, W_ACCSUB, W_Y, W_MIX, W_TOTAL, W_RES
  } wb_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PLCG, ST_PSEED, ST_DRIFT, ST_Z2, ST_T1, ST_T2, ST_SIN, ST_SINW,
    ST_BEND, ST_BENDW, ST_DIV, ST_DIVW, ST_E1, ST_E2, ST_E3, ST_ENT, ST_STEP,
    ST_STEPW, ST_FB0, ST_FA1, ST_FA2, ST_FY, ST_FG, ST_FMIX, ST_NOISE, ST_TOTAL,
    ST_OUT, ST_RES
  } fvs_state_e;

  typedef struct packed {
    mul_op_e op;
    wb_e     wb;
    logic    start;
    logic    band_clr;
    logic    band_inc;
  } fvs_cmd_t;

  typedef struct packed {
    logic last_band;
  } fvs_status_t;

  // Coefficient of one band rounded half up from Q2.30 to Q2.(cw-2).
  function automatic logic signed [63:0] band_coef(coef_kind_e kind, logic [2:0] band,
                                                   int unsigned cw);
    logic signed [63:0] q;
    int unsigned sh;
    unique case (kind)
      COEF_B0: q = B0_Q30[band];
      COEF_A1: q = A1_Q30[band];
      COEF_A2: q = A2_Q30[band];
      default: q = GAIN_Q30[band];
    endcase
    sh = 32 - cw;
    if (sh == 0) begin
      return q;
    end
    return (q + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

endpackage

// ===== rtl/fvs_ctrl.sv =====
// Sequencer of the formant vowel synthesizer: steps the shared multiplier schedule.
// Depends on fvs_pkg for the state, command and status types.
module fvs_ctrl import fvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  fvs_status_t status_i,
  output fvs_cmd_t    cmd_o
);

  fvs_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign in_stall_o  = (state_q != ST_IDLE);

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && out_stall_i;
    cmd_o.op       = M_NONE;
    cmd_o.wb       = W_NONE;
    cmd_o.start    = 1'b0;
    cmd_o.band_clr = 1'b0;
    cmd_o.band_inc = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_PLCG;
        end
      end
      ST_PLCG: begin
        cmd_o.op = M_PLCG;
        state_d  = ST_PSEED;
      end
      ST_PSEED: begin
        cmd_o.wb = W_PSEED;
        cmd_o.op = M_NLCG;
        state_d  = ST_DRIFT;
      end
      ST_DRIFT: begin
        cmd_o.wb = W_NSEED;
        cmd_o.op = M_DRIFT;
        state_d  = ST_Z2;
      end
      ST_Z2: begin
        cmd_o.wb = W_DRIFT;
        cmd_o.op = M_Z2;
        state_d  = ST_T1;
      end
      ST_T1: begin
        cmd_o.wb = W_Z2;
        cmd_o.op = M_T1;
        state_d  = ST_T2;
      end
      ST_T2: begin
        cmd_o.op = M_T2;
        state_d  = ST_SIN;
      end
      ST_SIN: begin
        cmd_o.op = M_S;
        state_d  = ST_SINW;
      end
      ST_SINW: begin
        cmd_o.wb = W_SINE;
        state_d  = ST_BEND;
      end
      ST_BEND: begin
        cmd_o.op = M_BEND;
        state_d  = ST_BENDW;
      end
      ST_BENDW: begin
        cmd_o.wb = W_BEND;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = M_DIV;
        state_d  = ST_DIVW;
      end
      ST_DIVW: begin
        cmd_o.wb = W_DIV;
        state_d  = ST_E1;
      end
      ST_E1: begin
        cmd_o.op = M_E1;
        state_d  = ST_E2;
      end
      ST_E2: begin
        cmd_o.op = M_E2;
        state_d  = ST_E3;
      end
      ST_E3: begin
        cmd_o.op = M_E3;
        state_d  = ST_ENT;
      end
      ST_ENT: begin
        cmd_o.wb = W_ENTRY;
        state_d  = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.op       = M_STEP;
        cmd_o.band_clr = 1'b1;
        state_d        = ST_STEPW;
      end
      ST_STEPW: begin
        cmd_o.wb = W_STEP;
        state_d  = ST_FB0;
      end
      ST_FB0: begin
        cmd_o.op = M_FB0;
        state_d  = ST_FA1;
      end
      ST_FA1: begin
        cmd_o.wb = W_ACC0;
        cmd_o.op = M_FA1;
        state_d  = ST_FA2;
      end
      ST_FA2: begin
        cmd_o.wb = W_ACCSUB;
        cmd_o.op = M_FA2;
        state_d  = ST_FY;
      end
      ST_FY: begin
        cmd_o.wb = W_Y;
        state_d  = ST_FG;
      end
      ST_FG: begin
        cmd_o.op = M_FG;
        state_d  = ST_FMIX;
      end
      ST_FMIX: begin
        cmd_o.wb = W_MIX;
        if (status_i.last_band) begin
          state_d = ST_NOISE;
        end else begin
          cmd_o.band_inc = 1'b1;
          state_d        = ST_FB0;
        end
      end
      ST_NOISE: begin
        cmd_o.op = M_NOISE;
        state_d  = ST_TOTAL;
      end
      ST_TOTAL: begin
        cmd_o.wb = W_TOTAL;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        cmd_o.op = M_OUT;
        state_d  = ST_RES;
      end
      ST_RES: begin
        // Keep the output product alive until the output register is free.
        cmd_o.op = M_OUT;
        if (slot_free) begin
          cmd_o.wb    = W_RES;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_PLCG)
    else $error("accepted transaction did not start the schedule");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RES && slot_free |=> out_valid_q && state_q == ST_IDLE)
    else $error("finished result was not presented");

  a_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FMIX && !status_i.last_band |=> state_q == ST_FB0)
    else $error("band loop ended early");

endmodule

// ===== rtl/fvs_datapath.sv =====
// Datapath of the formant vowel synthesizer: registers, one shared multiplier, writeback.
// Depends on fvs_pkg for commands, constants and the band coefficient function.
module fvs_datapath import fvs_pkg::*; #(
  parameter int unsigned BAND_COUNT       = BAND_COUNT_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
  parameter int unsigned EXP_TABLE_DEPTH  = EXP_DEPTH_DEF,
  parameter int unsigned COEF_WIDTH       = COEF_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fvs_cmd_t           cmd_i,
  output fvs_status_t        status_o,
  input  logic               restart_i,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic signed [15:0] sample_o,
  output logic               last_o
);

  localparam int unsigned BAND_W   = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int unsigned SINE_LOG = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned EXP_LOG  = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned CF       = COEF_WIDTH - 2;
  localparam logic [31:0] SINE_MASK = 32'hFFFF_FFFF << (32 - SINE_LOG);
  localparam logic [15:0] EXP_MASK  = 16'hFFFF << (16 - EXP_LOG);
  localparam logic signed [PROD_W-1:0] ROUND_CF = PROD_W'(1) <<< (CF - 1);
  localparam logic signed [PROD_W-1:0] Y_MAX = PROD_W'(8388607);
  localparam logic signed [PROD_W-1:0] Y_MIN = -PROD_W'(8388608);

  // Configuration registers.
  logic [31:0] base_inc_q, vib_inc_q;
  logic [15:0] vib_depth_q, drift_step_q, noise_level_q, out_gain_q;
  logic [14:0] drift_limit_q;
  logic [19:0] run_length_q;

  // Voice state.
  logic [31:0] saw_q, vib_q, pseed_q, nseed_q;
  logic signed [15:0] drift_q;
  logic [19:0] cnt_q;
  logic signed [20:0] ih0_q, ih1_q;
  logic signed [23:0] oh0_q [BAND_COUNT];
  logic signed [23:0] oh1_q [BAND_COUNT];
  logic [BAND_W-1:0] band_q;

  // Working registers.
  logic signed [PROD_W-1:0] p_q, p_d, acc_q, mix_q;
  logic signed [MUL_W-1:0] a_op, b_op;
  logic [16:0] z2_q;
  logic signed [17:0] sine_q;
  logic signed [19:0] bend_q, octq_q;
  logic [17:0] entry_q;
  logic signed [20:0] x_q;
  logic signed [23:0] y_q, total_q;
  logic signed [15:0] sample_q;
  logic last_q;

  // Derived values.
  logic signed [17:0] pr_r, nr_r;
  logic [31:0] vang;
  logic [16:0] z;
  logic [16:0] p_hi;
  logic [15:0] f;
  logic signed [6:0] sh_s;
  logic [PROD_W-1:0] step_full;
  logic [31:0] step_v;
  logic signed [63:0] c_b0, c_a1, c_a2, c_g;
  logic signed [18:0] dsum, dlim;
  logic signed [19:0] q0;
  logic signed [23:0] rem;
  logic signed [19:0] octq_n;
  logic signed [PROD_W-1:0] yv, mr, nr, tsum, rv;
  logic signed [23:0] y_n, tot_n;
  logic signed [15:0] res_n;
  logic [19:0] cnt_n;

  assign status_o.last_band = (band_q == BAND_W'(BAND_COUNT - 1));
  assign sample_o = sample_q;
  assign last_o   = last_q;

  // Random values of both generators, 2*hi16 - 65535.
  assign pr_r = $signed({1'b0, pseed_q[31:16], 1'b0}) - 18'sd65535;
  assign nr_r = $signed({1'b0, nseed_q[31:16], 1'b0}) - 18'sd65535;

  // Vibrato angle quantized to the sine table, folded into one quadrant.
  assign vang = vib_q & SINE_MASK;
  assign z    = vang[30] ? (17'd65536 - {1'b0, vang[29:14]}) : {1'b0, vang[29:14]};

  // Previous product scaled down by 2^16, fed straight into the next polynomial step.
  assign p_hi = p_q[32:16];

  // Octave split of the bend: fraction quantized to the exponent table.
  assign f         = octq_q[15:0] & EXP_MASK;
  assign sh_s      = 7'sd16 - 7'($signed(octq_q[19:16]));
  assign step_full = p_q >> sh_s[5:0];
  assign step_v    = step_full[31:0];

  // Filter coefficients of the current band.
  assign c_b0 = band_coef(COEF_B0, 3'(band_q), COEF_WIDTH);
  assign c_a1 = band_coef(COEF_A1, 3'(band_q), COEF_WIDTH);
  assign c_a2 = band_coef(COEF_A2, 3'(band_q), COEF_WIDTH);
  assign c_g  = band_coef(COEF_GAIN, 3'(band_q), COEF_WIDTH);

  // Shared multiplier operand selection.
  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (cmd_i.op)
      M_NONE: begin
      end
      M_PLCG: begin
        a_op = $signed({1'b0, pseed_q});
        b_op = $signed({1'b0, LCG_MUL});
      end
      M_NLCG: begin
        a_op = $signed({1'b0, nseed_q});
        b_op = $signed({1'b0, LCG_MUL});
      end
      M_DRIFT: begin
        a_op = $signed({17'd0, drift_step_q});
        b_op = MUL_W'(pr_r);
      end
      M_Z2: begin
        a_op = $signed({16'd0, z});
        b_op = $signed({16'd0, z});
      end
      M_T1: begin
        a_op = 33'sd5223;
        b_op = $signed({16'd0, p_hi});
      end
      M_T2: begin
        a_op = $signed({16'd0, 17'd42334 - p_hi});
        b_op = $signed({16'd0, z2_q});
      end
      M_S: begin
        a_op = $signed({16'd0, z});
        b_op = $signed({15'd0, 18'd102944 - {1'b0, p_hi}});
      end
      M_BEND: begin
        a_op = $signed({17'd0, vib_depth_q});
        b_op = MUL_W'(sine_q);
      end
      M_DIV: begin
        a_op = MUL_W'(bend_q);
        b_op = 33'sd87382;
      end
      M_E1: begin
        a_op = 33'sd5128;
        b_op = $signed({17'd0, f});
      end
      M_E2: begin
        a_op = $signed({16'd0, 17'd14816 + p_hi});
        b_op = $signed({17'd0, f});
      end
      M_E3: begin
        a_op = $signed({16'd0, 17'd45592 + p_hi});
        b_op = $signed({17'd0, f});
      end
      M_STEP: begin
        a_op = $signed({1'b0, base_inc_q});
        b_op = $signed({15'd0, entry_q});
      end
      M_FB0: begin
        a_op = $signed(c_b0[MUL_W-1:0]);
        b_op = MUL_W'(22'(x_q) - 22'(ih1_q));
      end
      M_FA1: begin
        a_op = $signed(c_a1[MUL_W-1:0]);
        b_op = MUL_W'(oh0_q[band_q]);
      end
      M_FA2: begin
        a_op = $signed(c_a2[MUL_W-1:0]);
        b_op = MUL_W'(oh1_q[band_q]);
      end
      M_FG: begin
        a_op = $signed(c_g[MUL_W-1:0]);
        b_op = MUL_W'(y_q);
      end
      M_NOISE: begin
        a_op = $signed({17'd0, noise_level_q});
        b_op = MUL_W'(nr_r);
      end
      M_OUT: begin
        a_op = MUL_W'(total_q);
        b_op = $signed({17'd0, out_gain_q});
      end
      default: begin
      end
    endcase
  end

  assign p_d = a_op * b_op;

  // Writeback arithmetic: drift clamp, divide by twelve, rounding and saturation.
  always_comb begin
    dsum = 19'(drift_q) + 19'($signed(p_q[33:16]));
    dlim = $signed({4'd0, drift_limit_q});
    q0   = $signed(p_q[39:20]);
    rem  = 24'(bend_q) - (24'(q0) <<< 3) - (24'(q0) <<< 2);
    if (rem < 0) begin
      octq_n = q0 - 20'sd1;
    end else if (rem >= 24'sd12) begin
      octq_n = q0 + 20'sd1;
    end else begin
      octq_n = q0;
    end
    yv = (acc_q - p_q + ROUND_CF) >>> CF;
    priority if (yv > Y_MAX) y_n = 24'sd8388607;
    else if (yv < Y_MIN) y_n = -24'sd8388608;
    else y_n = yv[23:0];
    mr   = (mix_q + ROUND_CF) >>> CF;
    nr   = (p_q + PROD_W'(2048)) >>> 12;
    tsum = mr + nr;
    priority if (tsum > Y_MAX) tot_n = 24'sd8388607;
    else if (tsum < Y_MIN) tot_n = -24'sd8388608;
    else tot_n = tsum[23:0];
    rv = (p_q + PROD_W'(65536)) >>> 17;
    priority if (rv > PROD_W'(32767)) res_n = 16'sd32767;
    else if (rv < -PROD_W'(32768)) res_n = -16'sd32768;
    else res_n = rv[15:0];
    cnt_n = cnt_q + 20'd1;
  end

  // Product register and working values.
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    unique case (cmd_i.wb)
      W_Z2:     z2_q    <= p_q[32:16];
      W_SINE:   sine_q  <= vang[31] ? -$signed({1'b0, p_q[32:16]})
                                    : $signed({1'b0, p_q[32:16]});
      W_BEND:   bend_q  <= $signed(p_q[35:16]) + 20'(drift_q);
      W_DIV:    octq_q  <= octq_n;
      W_ENTRY:  entry_q <= 18'd65536 + {1'b0, p_q[32:16]};
      W_STEP:   x_q     <= $signed({~saw_q[31], saw_q[30:11]});
      W_ACC0:   acc_q   <= p_q;
      W_ACCSUB: acc_q   <= acc_q - p_q;
      W_Y:      y_q     <= y_n;
      W_TOTAL:  total_q <= tot_n;
      default: begin
      end
    endcase
    if (cmd_i.band_clr) begin
      mix_q <= '0;
    end else if (cmd_i.wb == W_MIX) begin
      mix_q <= mix_q + p_q;
    end
  end

  // Configuration, voice state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_inc_q    <= BASE_INC_RST;
      vib_depth_q   <= VIB_DEPTH_RST;
      vib_inc_q     <= VIB_INC_RST;
      drift_step_q  <= DRIFT_STEP_RST;
      drift_limit_q <= DRIFT_LIMIT_RST;
      noise_level_q <= NOISE_LEVEL_RST;
      out_gain_q    <= OUT_GAIN_RST;
      run_length_q  <= RUN_LENGTH_RST;
      saw_q   <= '0;
      vib_q   <= '0;
      drift_q <= '0;
      pseed_q <= PITCH_SEED_RST;
      nseed_q <= NOISE_SEED_RST;
      cnt_q   <= '0;
      ih0_q   <= '0;
      ih1_q   <= '0;
      for (int i = 0; i < BAND_COUNT; i++) begin
        oh0_q[i] <= '0;
        oh1_q[i] <= '0;
      end
      band_q   <= '0;
      sample_q <= '0;
      last_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_BASE_INC:    base_inc_q    <= cfg_data_i;
          CFG_VIB_DEPTH:   vib_depth_q   <= cfg_data_i[15:0];
          CFG_VIB_INC:     vib_inc_q     <= cfg_data_i;
          CFG_DRIFT_STEP:  drift_step_q  <= cfg_data_i[15:0];
          CFG_DRIFT_LIMIT: drift_limit_q <= cfg_data_i[14:0];
          CFG_NOISE_LEVEL: noise_level_q <= cfg_data_i[15:0];
          CFG_OUT_GAIN:    out_gain_q    <= cfg_data_i[15:0];
          CFG_RUN_LENGTH:  run_length_q  <= cfg_data_i[19:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.band_clr) begin
        band_q <= '0;
      end else if (cmd_i.band_inc) begin
        band_q <= band_q + BAND_W'(1);
      end
      if (cmd_i.start && restart_i) begin
        // Restart reloads the whole voice before this sample.
        saw_q   <= '0;
        vib_q   <= '0;
        drift_q <= '0;
        pseed_q <= PITCH_SEED_RST;
        nseed_q <= NOISE_SEED_RST;
        cnt_q   <= '0;
        ih0_q   <= '0;
        ih1_q   <= '0;
        for (int i = 0; i < BAND_COUNT; i++) begin
          oh0_q[i] <= '0;
          oh1_q[i] <= '0;
        end
      end
      unique case (cmd_i.wb)
        W_PSEED: pseed_q <= p_q[31:0] + LCG_ADD;
        W_NSEED: nseed_q <= p_q[31:0] + LCG_ADD;
        W_DRIFT: begin
          priority if (dsum > dlim) drift_q <= dlim[15:0];
          else if (dsum < -dlim) drift_q <= 16'(-dlim);
          else drift_q <= dsum[15:0];
        end
        W_STEP: begin
          saw_q <= saw_q + step_v;
          vib_q <= vib_q + vib_inc_q;
        end
        W_Y: begin
          oh1_q[band_q] <= oh0_q[band_q];
          oh0_q[band_q] <= y_n;
        end
        W_TOTAL: begin
          ih1_q <= ih0_q;
          ih0_q <= x_q;
        end
        W_RES: begin
          sample_q <= res_n;
          last_q   <= (cnt_n == run_length_q);
          cnt_q    <= cnt_n;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/formant_vowel_synthesizer_unit.sv =====
// Each input transaction runs the schedule that produces one sample; a new transaction is taken
// only once the previous sample is finished, since the single shared multiplier
// forms all products of a sample one after another.
// A finished sample waits in the output register while the next transaction runs.
// Reset (asynchronous, active low) loads the register defaults and the start-of-voice state.
// Top level; depends on fvs_pkg, fvs_ctrl and fvs_datapath.
module formant_vowel_synthesizer_unit import fvs_pkg::*; #(
  parameter int unsigned BAND_COUNT       = BAND_COUNT_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
  parameter int unsigned EXP_TABLE_DEPTH  = EXP_DEPTH_DEF,
  parameter int unsigned COEF_WIDTH       = COEF_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  fvs_cmd_t    cmd;
  fvs_status_t status;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  fvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fvs_datapath #(
    .BAND_COUNT       (BAND_COUNT),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .EXP_TABLE_DEPTH  (EXP_TABLE_DEPTH),
    .COEF_WIDTH       (COEF_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .restart_i   (restart_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_o    (sample_o),
    .last_o      (last_o)
  );

endmodule
